@@ rtl/core/ntci_pkg.sv @@
// Shared constants and helpers for the thermistor table interpolator.
// Holds function codes, datapath widths and the fixed scale constants.
// No dependencies; imported by the top level of the block.
`default_nettype none

package ntci_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_V2T  = 2'd1;
   localparam logic [1:0] FUNC_T2V  = 2'd2;

   // Field widths.
   localparam int VOLT_W  = 12;
   localparam int DEG_W   = 8;
   localparam int QDEG_W  = 10;
   localparam int OUT_W   = 18;
   localparam int CNT_REG_W = 9;

   // Shared multiplier: signed operands and registered product.
   localparam int MUL_W   = 13;
   localparam int MUL_P_W = 2 * MUL_W;

   // Restoring divider: dividend bits and quotient steps.
   localparam int DIV_W     = 22;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_CNT_W = 5;

   // Scale constants.
   localparam logic signed [MUL_W-1:0] PRORATE_SCALE = 13'sd1000;
   localparam logic signed [OUT_W-1:0] ROOM_MILLIDEG = 18'sd25000;

   // Configuration register map.
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   // Sign-extend a stored temperature to the multiplier operand width.
   function automatic logic signed [MUL_W-1:0] deg_ext(input logic [DEG_W-1:0] d);
      deg_ext = {{(MUL_W - DEG_W){d[DEG_W-1]}}, d};
   endfunction

   // Zero-extend a stored voltage to the multiplier operand width.
   function automatic logic signed [MUL_W-1:0] volt_ext(input logic [VOLT_W-1:0] v);
      volt_ext = {{(MUL_W - VOLT_W){1'b0}}, v};
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ntc_table_interpolator.sv @@
// Top level of the thermistor table interpolator: table memory, search
// sequencer, shared multiplier and serial divider. Depends on ntci_pkg.
// Configuration is a single APB-style register holding the entry count.
`default_nettype none

// The block stores up to TABLE_DEPTH (millivolt, degree) pairs with voltage
// rising and temperature falling along the index. A load transfer writes one
// pair when it is accepted. A voltage query returns millidegrees and a
// temperature query returns millivolts: values outside the table clamp to the
// end entries, an exact match returns the partner column, and anything else
// is found by a binary search and linearly interpolated. A query is handled
// one at a time; how long it holds the block depends on whether it clamps
// at an end of the table, on the search probes, on the single table read
// port (one entry per cycle), on the 22-step restoring divider when it
// interpolates, and on whether the result register is still full.
// The result waits in an output register, so the next load may be taken
// meanwhile. The entry count is clamped to the range 2 to TABLE_DEPTH where
// it is used; the register itself keeps the value written.
module ntc_table_interpolator
   import ntci_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire                          clock,
   input  wire                          reset,
   // Request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [1:0]                   req_func,
   input  wire  [7:0]                   req_entry_index,
   input  wire  [VOLT_W-1:0]            req_entry_millivolts,
   input  wire  signed [DEG_W-1:0]      req_entry_degrees,
   input  wire  [VOLT_W-1:0]            req_query_millivolts,
   input  wire  signed [QDEG_W-1:0]     req_query_degrees,
   // Result channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_converted_value,
   // Configuration port
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [CSR_ADDR_W-1:0]        paddr,
   input  wire  [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int IDX_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FIRST  = 4'd1;
   localparam logic [3:0] S_LAST   = 4'd2;
   localparam logic [3:0] S_PROBE  = 4'd3;
   localparam logic [3:0] S_NEIGH  = 4'd4;
   localparam logic [3:0] S_INTERP = 4'd5;
   localparam logic [3:0] S_DIVSET = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_POST1  = 4'd8;
   localparam logic [3:0] S_POST2  = 4'd9;
   localparam logic [3:0] S_POST3  = 4'd10;
   localparam logic [3:0] S_SCALE  = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;

   // Table memories.
   logic [VOLT_W-1:0] volt_column_mem [TABLE_DEPTH];
   logic [DEG_W-1:0]  degree_column_mem [TABLE_DEPTH];

   // Control and datapath registers.
   logic [3:0]                 state_ff, state_in;
   logic [CNT_REG_W-1:0]       entries_ff;
   logic                       is_temp_ff, is_temp_in;
   logic signed [MUL_W-1:0]    q_ff, q_in;
   logic [IDX_W-1:0]           last_ff, last_in;
   logic [CNT_W-1:0]           low_ff, low_in, high_ff, high_in;
   logic [IDX_W-1:0]           mid_ff, mid_in;
   logic [IDX_W-1:0]           addr_ff, addr_in;
   logic                       up_ff, up_in;
   logic [VOLT_W-1:0]          rdv_ff;
   logic [DEG_W-1:0]           rdd_ff;
   logic [VOLT_W-1:0]          va_ff, va_in, v0_ff, v0_in;
   logic [DEG_W-1:0]           da_ff, da_in;
   logic [VOLT_W-1:0]          p0v_ff, p0v_in, p1v_ff, p1v_in;
   logic [DEG_W-1:0]           p0d_ff, p0d_in, p1d_ff, p1d_in;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [MUL_P_W-1:0]  prod_ff, acc_ff, acc_in;
   logic [VOLT_W-1:0]          rem_ff, rem_in, div_ff, div_in;
   logic [DIV_W-1:0]           quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]       dcnt_ff, dcnt_in;
   logic                       neg_ff, neg_in;
   logic signed [OUT_W-1:0]    res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]    rsp_value_ff, rsp_value_in;

   // Combinational helpers.
   logic                       req_xfer, load_wr, csr_wr;
   logic signed [MUL_W-1:0]    key_e, key_q;
   logic                       cont, fail;
   logic [CNT_W:0]             mid_sum;
   logic signed [MUL_P_W-1:0]  prod_mag;
   logic signed [MUL_W-1:0]    deg_diff, deg_mag;
   logic [VOLT_W:0]            div_shift, div_diff;
   logic signed [DIV_W:0]      quo_signed;
   logic signed [DIV_W+1:0]    volt_sum;
   logic signed [MUL_P_W-1:0]  acc_sum;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign load_wr   = req_xfer && (req_func == FUNC_LOAD) && (32'(req_entry_index) < TABLE_DEPTH);
   assign csr_wr    = psel & penable & pwrite & pready &
                      (paddr[CSR_ADDR_W-1] == REG_ENTRIES_IN_USE);

   // Configuration port: always ready, single register selected when the top address bit is zero.
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == REG_ENTRIES_IN_USE) begin
         prdata = {{(32 - CNT_REG_W){1'b0}}, entries_ff};
      end
   end

   // Table memories: one write from a load transfer, one registered read.
   always_ff @(posedge clock) begin
      if (load_wr) begin
         volt_column_mem[IDX_W'(req_entry_index)]   <= req_entry_millivolts;
         degree_column_mem[IDX_W'(req_entry_index)] <= req_entry_degrees;
      end
      rdv_ff <= volt_column_mem[addr_in];
      rdd_ff <= degree_column_mem[addr_in];
   end

   // Search keys: temperature is negated so that both columns rise with the index.
   assign key_e = is_temp_ff ? -deg_ext(rdd_ff) : volt_ext(rdv_ff);
   assign key_q = is_temp_ff ? -q_ff : q_ff;

   // Divider step and post-processing arithmetic.
   assign prod_mag   = prod_ff[MUL_P_W-1] ? -prod_ff : prod_ff;
   assign deg_diff   = deg_ext(p1d_ff) - deg_ext(p0d_ff);
   assign deg_mag    = deg_diff[MUL_W-1] ? -deg_diff : deg_diff;
   assign div_shift  = {rem_ff, quo_ff[DIV_W-1]};
   assign div_diff   = div_shift - {1'b0, div_ff};
   assign quo_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign volt_sum   = $signed({{(DIV_W + 2 - VOLT_W){1'b0}}, p0v_ff}) +
                       (DIV_W + 2)'(quo_signed);
   assign acc_sum    = acc_ff + prod_ff;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      is_temp_in = is_temp_ff;
      q_in       = q_ff;
      last_in    = last_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      mid_in     = mid_ff;
      addr_in    = addr_ff;
      up_in      = up_ff;
      va_in      = va_ff;
      da_in      = da_ff;
      v0_in      = v0_ff;
      p0v_in     = p0v_ff;
      p0d_in     = p0d_ff;
      p1v_in     = p1v_ff;
      p1d_in     = p1d_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_in     = div_ff;
      dcnt_in    = dcnt_ff;
      neg_in     = neg_ff;
      res_in     = res_ff;
      cont       = 1'b0;
      fail       = 1'b0;
      mid_sum    = '0;
      // By default the multiplier scales the entry just read to millidegrees.
      mul_a      = deg_ext(rdd_ff);
      mul_b      = PRORATE_SCALE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_func == FUNC_V2T || req_func == FUNC_T2V)) begin
               is_temp_in = (req_func == FUNC_T2V);
               if (req_func == FUNC_T2V) begin
                  q_in = MUL_W'(req_query_degrees);
               end else begin
                  q_in = $signed({{(MUL_W - VOLT_W){1'b0}}, req_query_millivolts});
               end
               priority if (entries_ff < CNT_REG_W'(2)) begin
                  last_in = IDX_W'(1);
               end else if (32'(entries_ff) > TABLE_DEPTH) begin
                  last_in = IDX_W'(TABLE_DEPTH - 1);
               end else begin
                  last_in = IDX_W'(entries_ff - CNT_REG_W'(1));
               end
               addr_in  = '0;
               state_in = S_FIRST;
            end
         end

         // First entry: clamp a query that lies before the table.
         S_FIRST: begin
            v0_in = rdv_ff;
            if (key_q < key_e) begin
               if (is_temp_ff) begin
                  res_in   = OUT_W'(rdv_ff);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCALE;
               end
            end else begin
               addr_in  = last_ff;
               state_in = S_LAST;
            end
         end

         // Last entry in use: clamp a query beyond the table, else start the search.
         S_LAST: begin
            if (key_q > key_e) begin
               if (is_temp_ff) begin
                  res_in   = OUT_W'(rdv_ff);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCALE;
               end
            end else begin
               low_in  = '0;
               high_in = CNT_W'(last_ff);
               cont    = 1'b1;
            end
         end

         // Probe at the mid point: exact match, or fetch the neighbor on the query side.
         S_PROBE: begin
            va_in = rdv_ff;
            da_in = rdd_ff;
            priority if (key_e == key_q) begin
               if (is_temp_ff) begin
                  res_in   = OUT_W'(rdv_ff);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCALE;
               end
            end else if (key_e < key_q) begin
               if (mid_ff < last_ff) begin
                  addr_in  = mid_ff + IDX_W'(1);
                  up_in    = 1'b1;
                  state_in = S_NEIGH;
               end else begin
                  low_in = CNT_W'(mid_ff) + CNT_W'(1);
                  cont   = 1'b1;
               end
            end else begin
               if (mid_ff == '0) begin
                  fail = 1'b1;
               end else begin
                  addr_in  = mid_ff - IDX_W'(1);
                  up_in    = 1'b0;
                  state_in = S_NEIGH;
               end
            end
         end

         // Neighbor check: a bracketing pair goes to interpolation.
         S_NEIGH: begin
            if (up_ff) begin
               if (key_e > key_q) begin
                  p0v_in   = va_ff;
                  p0d_in   = da_ff;
                  p1v_in   = rdv_ff;
                  p1d_in   = rdd_ff;
                  state_in = S_INTERP;
               end else begin
                  low_in = CNT_W'(mid_ff) + CNT_W'(1);
                  cont   = 1'b1;
               end
            end else begin
               if (key_e < key_q) begin
                  p0v_in   = rdv_ff;
                  p0d_in   = rdd_ff;
                  p1v_in   = va_ff;
                  p1d_in   = da_ff;
                  state_in = S_INTERP;
               end else begin
                  high_in = CNT_W'(mid_ff) - CNT_W'(1);
                  cont    = 1'b1;
               end
            end
         end

         // Degenerate pairs, else form the numerator product.
         S_INTERP: begin
            if (is_temp_ff) begin
               mul_a = q_ff - deg_ext(p0d_ff);
               mul_b = volt_ext(p1v_ff) - volt_ext(p0v_ff);
               if (p1d_ff == p0d_ff) begin
                  res_in   = OUT_W'(p0v_ff);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_DIVSET;
               end
            end else begin
               mul_a = volt_ext(p1v_ff) - q_ff;
               mul_b = PRORATE_SCALE;
               if (p1v_ff == p0v_ff) begin
                  res_in   = ROOM_MILLIDEG;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_DIVSET;
               end
            end
         end

         // Load the divider with magnitudes; the sign is restored afterwards.
         S_DIVSET: begin
            quo_in  = prod_mag[DIV_W-1:0];
            rem_in  = '0;
            dcnt_in = '0;
            if (is_temp_ff) begin
               div_in = deg_mag[VOLT_W-1:0];
               neg_in = prod_ff[MUL_P_W-1] ^ deg_diff[MUL_W-1];
            end else begin
               div_in = p1v_ff - p0v_ff;
               neg_in = 1'b0;
            end
            state_in = S_DIV;
         end

         // One quotient bit per cycle.
         S_DIV: begin
            if (div_diff[VOLT_W] == 1'b0) begin
               rem_in = div_diff[VOLT_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = div_shift[VOLT_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
            if (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_POST1;
            end else begin
               dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            end
         end

         // Temperature query finishes here; voltage query scales the proration.
         S_POST1: begin
            mul_a = deg_ext(p0d_ff) - deg_ext(p1d_ff);
            mul_b = $signed({3'b000, quo_ff[9:0]});
            if (is_temp_ff) begin
               res_in   = volt_sum[OUT_W-1:0];
               state_in = S_EMIT;
            end else begin
               state_in = S_POST2;
            end
         end

         S_POST2: begin
            acc_in   = prod_ff;
            mul_a    = deg_ext(p1d_ff);
            mul_b    = PRORATE_SCALE;
            state_in = S_POST3;
         end

         S_POST3: begin
            res_in   = acc_sum[OUT_W-1:0];
            state_in = S_EMIT;
         end

         // Clamp or exact match on a voltage query: degrees times the scale.
         S_SCALE: begin
            res_in   = prod_ff[OUT_W-1:0];
            state_in = S_EMIT;
         end

         // Hand the result to the output register once it is free.
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Continue the search with the updated bounds, or give up.
      if (cont) begin
         if (low_in <= high_in) begin
            mid_sum  = {1'b0, low_in} + {1'b0, high_in};
            mid_in   = mid_sum[IDX_W:1];
            addr_in  = mid_sum[IDX_W:1];
            state_in = S_PROBE;
         end else begin
            fail = 1'b1;
         end
      end
      if (fail) begin
         res_in   = is_temp_ff ? OUT_W'(v0_ff) : '0;
         state_in = S_EMIT;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= CNT_REG_W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            entries_ff <= pwdata[CNT_REG_W-1:0];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      is_temp_ff   <= is_temp_in;
      q_ff         <= q_in;
      last_ff      <= last_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      addr_ff      <= addr_in;
      up_ff        <= up_in;
      va_ff        <= va_in;
      da_ff        <= da_in;
      v0_ff        <= v0_in;
      p0v_ff       <= p0v_in;
      p0d_ff       <= p0d_in;
      p1v_ff       <= p1v_in;
      p1d_ff       <= p1d_in;
      prod_ff      <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_ff       <= div_in;
      dcnt_ff      <= dcnt_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_converted_value = rsp_value_ff;

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the thermistor table interpolator.
// Drives table loads and conversion queries, predicts each converted value
// in a scoreboard class, and depends on ntci_pkg and ntc_table_interpolator.
`timescale 1ns / 1ps

module tb;
   import ntci_pkg::*;

   localparam int TB_TABLE_DEPTH = 256;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ENTRY_COUNT_ADDR = CSR_ADDR_W'(4 * REG_ENTRIES_IN_USE);
   localparam longint SCALE_MILLI = 1000;
   localparam longint ROOM_TEMP_MILLI = 25000;
   localparam int SETTLE_CYCLES = 80;
   localparam int END_CYCLES = 120;
   localparam int QUERIES_PER_PHASE = 30;
   localparam int CYCLE_LIMIT = 600000;

   // One request transfer, one field per port.
   typedef struct {
      logic [1:0]               func;
      logic [7:0]               entry_index;
      logic [VOLT_W-1:0]        entry_mv;
      logic signed [DEG_W-1:0]  entry_deg;
      logic [VOLT_W-1:0]        query_mv;
      logic signed [QDEG_W-1:0] query_deg;
   } conv_request_type;

   // Keeps a copy of the table and entry count, and queues the converted
   // values that the block owes for accepted queries.
   class ntc_conversion_tracker;
      logic [CNT_REG_W-1:0]     entry_count;
      logic [VOLT_W-1:0]        volt_col [TB_TABLE_DEPTH];
      logic signed [DEG_W-1:0]  deg_col [TB_TABLE_DEPTH];
      logic signed [OUT_W-1:0]  pending_conversions [$];
      int                       mismatch_count;

      function new();
         entry_count = 2;
         mismatch_count = 0;
      endfunction

      function void set_entry_count(logic [CNT_REG_W-1:0] value);
         entry_count = value;
      endfunction

      // The entry count is clamped to the range the table supports.
      function int unsigned used_entries();
         if (entry_count < 2) return 2;
         if (entry_count > TB_TABLE_DEPTH) return TB_TABLE_DEPTH;
         return entry_count;
      endfunction

      function longint vat(int unsigned i);
         return longint'(volt_col[i]);
      endfunction

      function longint dat(int unsigned i);
         return longint'(deg_col[i]);
      endfunction

      // Prorate out of 1000 between a bracketing pair of voltages.
      function longint prorate_millideg(longint q, int unsigned a, int unsigned b);
         longint span_v;
         span_v = vat(b) - vat(a);
         if (span_v == 0) return ROOM_TEMP_MILLI;
         return (dat(a) - dat(b)) * (((vat(b) - q) * SCALE_MILLI) / span_v)
                + dat(b) * SCALE_MILLI;
      endfunction

      // Voltage to millidegrees: clamp, exact match or binary search.
      function longint millideg_from_volts(longint q);
         int unsigned n, lo, hi, mid;
         n = used_entries();
         lo = 0;
         hi = n - 1;
         if (q < vat(0)) return dat(0) * SCALE_MILLI;
         if (q > vat(n - 1)) return dat(n - 1) * SCALE_MILLI;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (vat(mid) > q) begin
               if (mid == 0) break;
               if (vat(mid - 1) < q) return prorate_millideg(q, mid - 1, mid);
               hi = mid - 1;
            end else if (vat(mid) < q) begin
               if (mid + 1 < n && vat(mid + 1) > q) return prorate_millideg(q, mid, mid + 1);
               lo = mid + 1;
            end else begin
               return dat(mid) * SCALE_MILLI;
            end
         end
         return 0;
      endfunction

      // Linear step between two temperatures; the division truncates.
      function longint stepped_millivolts(longint q, int unsigned s, int unsigned e);
         if (dat(e) == dat(s)) return vat(s);
         return vat(s) + ((q - dat(s)) * (vat(e) - vat(s))) / (dat(e) - dat(s));
      endfunction

      // Degrees to millivolts: the temperature column falls with the index.
      function longint millivolts_from_deg(longint q);
         int unsigned n, lo, hi, mid;
         n = used_entries();
         lo = 0;
         hi = n - 1;
         if (q > dat(0)) return vat(0);
         if (q < dat(n - 1)) return vat(n - 1);
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (dat(mid) > q) begin
               if (mid + 1 < n && dat(mid + 1) < q) return stepped_millivolts(q, mid, mid + 1);
               lo = mid + 1;
            end else if (dat(mid) < q) begin
               if (mid == 0) break;
               if (dat(mid - 1) > q) return stepped_millivolts(q, mid - 1, mid);
               hi = mid - 1;
            end else begin
               return vat(mid);
            end
         end
         return vat(0);
      endfunction

      // Apply an accepted request transfer: loads update the table and
      // queries queue the value they must return.
      function void note_request(conv_request_type r);
         longint value;
         case (r.func)
            FUNC_LOAD: begin
               volt_col[r.entry_index] = r.entry_mv;
               deg_col[r.entry_index] = r.entry_deg;
            end
            FUNC_V2T: begin
               value = millideg_from_volts(longint'(r.query_mv));
               pending_conversions.push_back(value[OUT_W-1:0]);
            end
            FUNC_T2V: begin
               value = millivolts_from_deg(longint'(r.query_deg));
               pending_conversions.push_back(value[OUT_W-1:0]);
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, logic signed [OUT_W-1:0] got,
                           logic signed [OUT_W-1:0] want);
         mismatch_count++;
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      endtask

      // Compare one result transfer against the oldest pending value.
      task check_value(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (pending_conversions.size() == 0) begin
            report_mismatch("result with no pending query", got, '0);
         end else begin
            want = pending_conversions.pop_front();
            if (got !== want) report_mismatch("converted_value", got, want);
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_func;
   logic [7:0]               req_entry_index;
   logic [VOLT_W-1:0]        req_entry_millivolts;
   logic signed [DEG_W-1:0]  req_entry_degrees;
   logic [VOLT_W-1:0]        req_query_millivolts;
   logic signed [QDEG_W-1:0] req_query_degrees;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [OUT_W-1:0]  rsp_converted_value;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_W-1:0]    paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   ntc_conversion_tracker    sb;
   int                       burst_left;
   int                       cycle_count;
   bit                       full_table_ready;

   ntc_table_interpolator #(
      .TABLE_DEPTH(TB_TABLE_DEPTH)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_entry_index      (req_entry_index),
      .req_entry_millivolts (req_entry_millivolts),
      .req_entry_degrees    (req_entry_degrees),
      .req_query_millivolts (req_query_millivolts),
      .req_query_degrees    (req_query_degrees),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_converted_value  (rsp_converted_value),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit: a correct run finishes far below this count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Every accepted result transfer is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) sb.check_value(rsp_converted_value);
   end

   // The receiver switches between stall patterns at random.
   initial begin : rsp_stall_pattern
      int mode;
      int unsigned tick;
      rsp_ready = 1'b0;
      tick = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(40, 120)) begin
            @(negedge clock);
            tick++;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 5) == 0);
               default: rsp_ready <= ((tick % 24) >= 18);
            endcase
         end
      end
   end

   function automatic conv_request_type make_load(logic [7:0] idx, logic [VOLT_W-1:0] mv,
                                                  logic signed [DEG_W-1:0] deg);
      conv_request_type r;
      r.func = FUNC_LOAD;
      r.entry_index = idx;
      r.entry_mv = mv;
      r.entry_deg = deg;
      r.query_mv = VOLT_W'($urandom);
      r.query_deg = QDEG_W'($urandom);
      return r;
   endfunction

   function automatic conv_request_type make_query(logic [1:0] func, logic [VOLT_W-1:0] qmv,
                                                   logic signed [QDEG_W-1:0] qdeg);
      conv_request_type r;
      r.func = func;
      r.entry_index = 8'($urandom);
      r.entry_mv = VOLT_W'($urandom);
      r.entry_deg = DEG_W'($urandom);
      r.query_mv = qmv;
      r.query_deg = qdeg;
      return r;
   endfunction

   // Send one request transfer. Called and returns at a falling edge; valid
   // stays high while a burst lasts and drops when the burst ends.
   task automatic send_request(input conv_request_type r);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_func <= r.func;
      req_entry_index <= r.entry_index;
      req_entry_millivolts <= r.entry_mv;
      req_entry_degrees <= r.entry_deg;
      req_query_millivolts <= r.query_mv;
      req_query_degrees <= r.query_deg;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      burst_left--;
      @(negedge clock);
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic stop_sender();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
   endtask

   // Hold off until every pending conversion has come back.
   task automatic wait_drained();
      while (sb.pending_conversions.size() != 0) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle.
   task automatic write_entry_count(input logic [CNT_REG_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ENTRY_COUNT_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_entry_count(value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Load every entry in use: mostly strictly monotonic, sometimes with
   // flat steps, sometimes random.
   task automatic load_table(input int unsigned n);
      int unsigned kind, step_floor, vstep, dstep, i;
      int v, d;
      kind = (n == TB_TABLE_DEPTH) ? 2 : $urandom_range(0, 9);
      step_floor = (kind == 1) ? 0 : 1;
      vstep = 4095 / (n - 1);
      if (vstep > 1500) vstep = 1500;
      dstep = 255 / (n - 1);
      if (dstep > 100) dstep = 100;
      v = $urandom_range(0, 4095 - (n - 1) * vstep);
      d = 127 - int'($urandom_range(0, 255 - (n - 1) * dstep));
      for (i = 0; i < n; i++) begin
         if (kind == 0) begin
            send_request(make_load(i[7:0], VOLT_W'($urandom), DEG_W'($urandom)));
         end else begin
            send_request(make_load(i[7:0], v[VOLT_W-1:0], d[DEG_W-1:0]));
            v += int'($urandom_range(step_floor, vstep));
            d -= int'($urandom_range(step_floor, dstep));
         end
      end
   endtask

   // One random item aimed at the current table: exact hits, values
   // between the ends, and values anywhere in the field range.
   task automatic random_item(input int unsigned n);
      int unsigned sel, pick, idx;
      logic [VOLT_W-1:0] qmv;
      logic signed [QDEG_W-1:0] qdeg;
      sel = $urandom_range(0, 99);
      pick = $urandom_range(0, n - 1);
      qmv = VOLT_W'($urandom);
      qdeg = QDEG_W'($urandom);
      case ($urandom_range(0, 2))
         0: begin
            qmv = sb.volt_col[pick];
            qdeg = sb.deg_col[pick];
         end
         1: begin
            qmv = VOLT_W'($urandom_range(sb.volt_col[0], sb.volt_col[n - 1]));
            qdeg = QDEG_W'(int'($urandom_range(sb.deg_col[0] + 512,
                                               sb.deg_col[n - 1] + 512)) - 512);
         end
         default: ;
      endcase
      if (sel < 40) begin
         send_request(make_query(FUNC_V2T, qmv, qdeg));
      end else if (sel < 78) begin
         send_request(make_query(FUNC_T2V, qmv, qdeg));
      end else if (sel < 84) begin
         send_request(make_query(FUNC_UNUSED, qmv, qdeg));
      end else if (sel < 94) begin
         // Rewrite an entry in use unchanged, or scribble one outside it.
         idx = $urandom_range(0, TB_TABLE_DEPTH - 1);
         if (idx < n) begin
            send_request(make_load(idx[7:0], sb.volt_col[idx], sb.deg_col[idx]));
         end else begin
            send_request(make_load(idx[7:0], VOLT_W'($urandom), DEG_W'($urandom)));
            full_table_ready = 1'b0;
         end
      end else if (sel < 96) begin
         stop_sender();
         wait_drained();
      end else begin
         send_request(make_query(2'($urandom_range(FUNC_V2T, FUNC_T2V)),
                                 VOLT_W'($urandom), QDEG_W'($urandom)));
      end
   endtask

   // A phase changes the entry count while idle, loads a table for it unless a
   // full table is already loaded, and then runs random queries against it.
   task automatic run_phase(input logic [CNT_REG_W-1:0] count);
      int unsigned n;
      stop_sender();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_entry_count(count);
      n = sb.used_entries();
      if (!(n == TB_TABLE_DEPTH && full_table_ready)) load_table(n);
      full_table_ready = (n == TB_TABLE_DEPTH);
      repeat (QUERIES_PER_PHASE) random_item(n);
   endtask

   initial begin : stimulus
      logic [CNT_REG_W-1:0] phase_counts [12];
      phase_counts = '{9'd3, 9'd0, 9'd9, 9'd256, 9'd511, 9'd400,
                       9'd1, 9'd17, 9'd64, 9'd5, 9'd2, 9'd33};
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_LOAD;
      req_entry_index = '0;
      req_entry_millivolts = '0;
      req_entry_degrees = '0;
      req_query_millivolts = '0;
      req_query_degrees = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      cycle_count = 0;
      full_table_ready = 1'b0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset entry count of two: full-scale table.
      send_request(make_load(8'd0, 12'd0, 8'sd127));
      send_request(make_load(8'd1, 12'd4095, 8'sh80));
      send_request(make_query(FUNC_V2T, 12'd0, '0));
      send_request(make_query(FUNC_V2T, 12'd4095, '0));
      send_request(make_query(FUNC_V2T, 12'd2048, '0));
      send_request(make_query(FUNC_T2V, '0, 10'sd127));
      send_request(make_query(FUNC_T2V, '0, -10'sd128));
      send_request(make_query(FUNC_T2V, '0, 10'sd511));
      send_request(make_query(FUNC_T2V, '0, 10'sh200));
      send_request(make_query(FUNC_T2V, '0, 10'sd0));

      // Narrow table: clamps just outside both ends and interpolation
      // just inside them.
      send_request(make_load(8'd0, 12'd1000, 8'sd100));
      send_request(make_load(8'd1, 12'd3000, 8'sd20));
      send_request(make_query(FUNC_V2T, 12'd999, '0));
      send_request(make_query(FUNC_V2T, 12'd3001, '0));
      send_request(make_query(FUNC_V2T, 12'd1001, '0));
      send_request(make_query(FUNC_V2T, 12'd2999, '0));
      send_request(make_query(FUNC_T2V, '0, 10'sd101));
      send_request(make_query(FUNC_T2V, '0, 10'sd19));
      send_request(make_query(FUNC_T2V, '0, 10'sd99));
      send_request(make_query(FUNC_T2V, '0, 10'sd21));

      // The unused function code, and loads outside the entries in use.
      send_request(make_query(FUNC_UNUSED, 12'd4095, 10'sh200));
      send_request(make_load(8'd255, 12'd4095, 8'sh80));
      send_request(make_load(8'd128, 12'd2048, 8'sd0));

      foreach (phase_counts[p]) run_phase(phase_counts[p]);

      stop_sender();
      wait_drained();
      repeat (END_CYCLES) @(negedge clock);
      if (sb.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/ntci_pkg.sv
rtl/core/ntc_table_interpolator.sv
test/tb.sv
